>>> src/bdq_pkg.sv
// bdq_pkg: shared types, codes and conversion functions of the row dequantizer
// used by block_dequantizer_f16_q4_q8_top and its checker
package bdq_pkg;

  // format codes of the format_select register
  typedef enum logic [1:0] {
    FMT_F32  = 2'd0,
    FMT_F16  = 2'd1,
    FMT_Q4_0 = 2'd2,
    FMT_Q8_0 = 2'd3
  } fmt_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_FORMAT  = 2'd0,
    REG_ROW_LEN = 2'd1,
    REG_NONE2   = 2'd2,
    REG_NONE3   = 2'd3
  } reg_e;

  localparam int unsigned MaxRowElems = 65536;
  localparam int unsigned LenW        = 17;
  localparam int unsigned IdxW        = 16;
  localparam logic [LenW-1:0] LenReset = LenW'(32);
  localparam logic [5:0] Q4EndPhase  = 6'd17;
  localparam logic [5:0] Q8EndPhase  = 6'd33;
  localparam logic [31:0] CanonNan   = 32'h7FC0_0000;

  // one result of the output buffer
  typedef struct packed {
    logic [31:0]     value;
    logic [IdxW-1:0] idx;
    logic            last_row;
  } res_t;

  // exact half to single, denormals normalized, inf/nan payload kept
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic       s;
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] lead;
    logic [3:0] k;
    logic [19:0] t;
    logic [7:0] ex;
    s = h[15];
    e = h[14:10];
    m = h[9:0];
    lead = 4'd0;
    k = 4'd0;
    t = 20'd0;
    ex = 8'd0;
    if (e == 5'd0) begin
      if (m == 10'd0) begin
        half_to_single = {s, 31'd0};
      end else begin
        // leading one of the denormal mantissa
        for (int i = 0; i < 10; i++) begin
          if (m[i]) lead = 4'(i);
        end
        k = 4'd10 - lead;
        t = {10'd0, m} << k;
        ex = 8'd113 - {4'd0, k};
        half_to_single = {s, ex, t[9:0], 13'd0};
      end
    end else if (e == 5'h1F) begin
      half_to_single = {s, 8'hFF, m, 13'd0};
    end else begin
      ex = {3'd0, e} + 8'd112;
      half_to_single = {s, ex, m, 13'd0};
    end
  endfunction

  // exact product of a small integer and an f16 block scale; a denormal scale gives zero
  function automatic logic [31:0] scaled(input logic signed [8:0] q, input logic [15:0] h);
    logic        sgn;
    logic [7:0]  a;
    logic [4:0]  e;
    logic [18:0] p;
    logic [4:0]  lead;
    logic [41:0] t;
    logic [7:0]  ex;
    sgn = h[15] ^ q[8];
    a = q[8] ? 8'(-q) : q[7:0];
    e = h[14:10];
    p = 19'(a) * 19'({1'b1, h[9:0]});
    lead = 5'd0;
    t = 42'd0;
    ex = 8'd0;
    if (e == 5'h1F) begin
      scaled = (a == 8'd0) ? CanonNan : {sgn, 8'hFF, 23'd0};
    end else if (e == 5'd0 || a == 8'd0) begin
      scaled = {sgn, 31'd0};
    end else begin
      // leading one of the 19-bit product
      for (int i = 0; i < 19; i++) begin
        if (p[i]) lead = 5'(i);
      end
      t = {23'd0, p} << (5'd23 - lead);
      ex = {3'd0, lead} + {3'd0, e} + 8'd102;
      scaled = {sgn, ex, t[22:0]};
    end
  endfunction

endpackage

>>> src/block_dequantizer_f16_q4_q8_top.sv
// block_dequantizer_f16_q4_q8_top: byte stream to single-precision row dequantizer
// depends on bdq_pkg
//
// channel  direction  handshake            payload
// in       input      in_valid_i/in_stall_o    data_byte_i
// out      output     out_valid_o/out_stall_i  value_bits_o, element_index_o,
//                                              last_of_row_o, last_of_item_o
// cfg      input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// one byte is taken per cycle while in_stall_o is low; its results show in the cycle after
// from a two-entry result buffer. a q4_0 byte with two results holds the input until its
// first result drains, so the output port (one result a cycle) sets the rate there.
// reset clears registers to format f32, row length 32, empty stream.
// output stall holds the buffer; input stalls when it is full or its one result stalls.
module block_dequantizer_f16_q4_q8_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] value_bits_o,
  output logic [15:0] element_index_o,
  output logic        last_of_row_o,
  output logic        last_of_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  logic [1:0]  fmt_q;
  logic [16:0] len_q;
  logic [5:0]  phase_q, phase_d;
  logic [23:0] asm_q, asm_d;
  logic [15:0] scale_q, scale_d;
  logic [16:0] count_q, count_d;
  bdq_pkg::res_t slot0_q, slot1_q, r0, r1;
  logic [1:0]  cnt_q, n;
  logic        in_acc, out_acc, cfg_acc, cfg_hit;
  logic [16:0] eff_len, c1, c2;
  logic [5:0]  endp;
  logic        emit0, emit1, plast;
  logic signed [8:0] q0, q1;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;
  assign cfg_hit     = cfg_acc & (cfg_index_i == bdq_pkg::REG_FORMAT
                                  || cfg_index_i == bdq_pkg::REG_ROW_LEN);

  // input is taken only while the buffer is empty or drains its only result this cycle
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_acc     = out_valid_o & ~out_stall_i;
  assign in_stall_o  = (cnt_q == 2'd2) || (cnt_q == 2'd1 && out_stall_i);
  assign in_acc      = in_valid_i & ~in_stall_o;

  assign value_bits_o    = slot0_q.value;
  assign element_index_o = slot0_q.idx;
  assign last_of_row_o   = slot0_q.last_row;
  assign last_of_item_o  = (cnt_q == 2'd1);

  // effective row length
  always_comb begin
    if (len_q == 17'd0) eff_len = 17'd1;
    else if (len_q > 17'(bdq_pkg::MaxRowElems)) eff_len = 17'(bdq_pkg::MaxRowElems);
    else eff_len = len_q;
  end

  assign c1    = count_q + 17'd1;
  assign c2    = count_q + 17'd2;
  assign plast = (c1 >= eff_len);
  assign emit0 = (count_q < eff_len);
  assign emit1 = (c1 < eff_len);
  assign endp  = (fmt_q == bdq_pkg::FMT_Q4_0) ? bdq_pkg::Q4EndPhase : bdq_pkg::Q8EndPhase;
  assign q0    = (fmt_q == bdq_pkg::FMT_Q4_0) ? (9'sd0 + $signed({5'd0, data_byte_i[3:0]}) - 9'sd8)
                                              : $signed({data_byte_i[7], data_byte_i});
  assign q1    = $signed({5'd0, data_byte_i[7:4]}) - 9'sd8;

  // decode of one byte: results and next stream state
  always_comb begin
    phase_d = phase_q;
    asm_d   = asm_q;
    scale_d = scale_q;
    count_d = count_q;
    n       = 2'd0;
    r0      = '0;
    r1      = '0;
    r0.idx  = count_q[15:0];
    r1.idx  = c1[15:0];
    case (fmt_q)
      bdq_pkg::FMT_F32: begin
        if (phase_q < 6'd3) begin
          case (phase_q[1:0])
            2'd0:    asm_d = {asm_q[23:8], data_byte_i};
            2'd1:    asm_d = {asm_q[23:16], data_byte_i, asm_q[7:0]};
            default: asm_d = {data_byte_i, asm_q[15:0]};
          endcase
          phase_d = phase_q + 6'd1;
        end else begin
          r0.value    = {data_byte_i, asm_q};
          r0.last_row = plast;
          n           = 2'd1;
          phase_d     = 6'd0;
          asm_d       = '0;
          count_d     = plast ? 17'd0 : c1;
        end
      end
      bdq_pkg::FMT_F16: begin
        if (phase_q == 6'd0) begin
          asm_d   = {16'd0, data_byte_i};
          phase_d = 6'd1;
        end else begin
          r0.value    = bdq_pkg::half_to_single({data_byte_i, asm_q[7:0]});
          r0.last_row = plast;
          n           = 2'd1;
          phase_d     = 6'd0;
          asm_d       = '0;
          count_d     = plast ? 17'd0 : c1;
        end
      end
      default: begin
        if (phase_q == 6'd0) begin
          asm_d   = {16'd0, data_byte_i};
          phase_d = 6'd1;
        end else if (phase_q == 6'd1) begin
          scale_d = {data_byte_i, asm_q[7:0]};
          asm_d   = '0;
          phase_d = 6'd2;
        end else begin
          r0.value    = bdq_pkg::scaled(q0, scale_q);
          r0.last_row = (c1 == eff_len);
          r1.value    = bdq_pkg::scaled(q1, scale_q);
          r1.last_row = (c2 == eff_len);
          if (fmt_q == bdq_pkg::FMT_Q4_0) begin
            n       = {1'b0, emit0} + {1'b0, emit1};
            count_d = c2;
          end else begin
            n       = {1'b0, emit0};
            count_d = c1;
          end
          // block end: rewind the row position once it is used up
          if (phase_q >= endp) begin
            phase_d = 6'd0;
            if (count_d >= eff_len) count_d = 17'd0;
          end else begin
            phase_d = phase_q + 6'd1;
          end
        end
      end
    endcase
  end

  // configuration and stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= bdq_pkg::FMT_F32;
      len_q   <= bdq_pkg::LenReset;
      phase_q <= '0;
      asm_q   <= '0;
      scale_q <= '0;
      count_q <= '0;
    end else if (cfg_hit) begin
      if (cfg_index_i == bdq_pkg::REG_FORMAT) fmt_q <= cfg_data_i[1:0];
      else len_q <= cfg_data_i;
      phase_q <= '0;
      asm_q   <= '0;
      scale_q <= '0;
      count_q <= '0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      asm_q   <= asm_d;
      scale_q <= scale_d;
      count_q <= count_d;
    end
  end

  // result buffer count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc) begin
      cnt_q <= n;
    end else if (out_acc) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // result buffer payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      slot0_q <= r0;
      slot1_q <= r1;
    end else if (out_acc) begin
      slot0_q <= slot1_q;
    end
  end

endmodule

>>> src/bdq_checker.sv
// bdq_checker: port-level assertions of the row dequantizer, bound to the top level
// depends on block_dequantizer_f16_q4_q8_top
module bdq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] value_bits_o,
  input logic [15:0] element_index_o,
  input logic        last_of_row_o,
  input logic        last_of_item_o,
  input logic        cfg_valid_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_bits_o))
    else $error("stalled result changed");

  // second result of a byte follows at once
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_item_o |=> out_valid_o)
    else $error("second result of a request missing");

  // a new row starts at index zero
  a_row_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_of_row_o && !cfg_valid_i
      |=> !out_valid_o || element_index_o == 16'd0)
    else $error("row did not restart at index zero");

  // row index steps by one inside a request pair
  a_pair_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_item_o
      |=> element_index_o == $past(element_index_o) + 16'd1)
    else $error("paired results not consecutive");

endmodule

bind block_dequantizer_f16_q4_q8_top bdq_checker u_bdq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .value_bits_o    (value_bits_o),
  .element_index_o (element_index_o),
  .last_of_row_o   (last_of_row_o),
  .last_of_item_o  (last_of_item_o),
  .cfg_valid_i     (cfg_valid_i)
);

>>> tb/block_dequantizer_f16_q4_q8_checker.sv
// row dequantizer checker: watches the config, input and output channels,
// predicts every result and compares it; depends on bdq_pkg
module block_dequantizer_f16_q4_q8_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] value_bits_i,
  input  logic [15:0] element_index_i,
  input  logic        last_of_row_i,
  input  logic        last_of_item_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  typedef struct {
    logic [31:0] value;
    logic [15:0] idx;
    logic        last_row;
    logic        last_item;
  } elem_t;

  elem_t          elem_q[$];
  bdq_pkg::fmt_e  fmt;
  logic [16:0]    rlen;
  logic [5:0]     phase;
  logic [23:0]    asm_bytes;
  logic [15:0]    scale;
  logic [16:0]    count;

  assign pending_o = elem_q.size();

  function automatic logic [31:0] row_len_eff();
    if (rlen == 17'd0) return 32'd1;
    if (rlen > bdq_pkg::MaxRowElems) return bdq_pkg::MaxRowElems;
    return 32'(rlen);
  endfunction

  // exact f16 widening, denormals renormalized
  function automatic logic [31:0] f16_widen(input logic [15:0] h);
    logic [10:0] mm;
    int          k;
    mm = {1'b0, h[9:0]};
    k = 0;
    if (h[14:10] == 5'd0) begin
      if (mm == 11'd0) return {h[15], 31'd0};
      while (!mm[10]) begin
        mm = mm << 1;
        k++;
      end
      return {h[15], 8'(113 - k), mm[9:0], 13'd0};
    end
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
    return {h[15], 8'(h[14:10] + 112), h[9:0], 13'd0};
  endfunction

  // q times scale; the product fits a single mantissa so it is exact; a denormal scale gives zero
  function automatic logic [31:0] block_product(input int q, input logic [15:0] h);
    logic        neg;
    int unsigned mag;
    int unsigned p;
    int          msb;
    logic [41:0] t;
    neg = h[15] ^ (q < 0);
    mag = (q < 0) ? -q : q;
    if (h[14:10] == 5'h1F) return (mag == 0) ? bdq_pkg::CanonNan : {neg, 8'hFF, 23'd0};
    if (h[14:10] == 5'd0 || mag == 0) return {neg, 31'd0};
    p = mag * (1024 + h[9:0]);
    msb = 0;
    for (int i = 0; i < 20; i++) if (p[i]) msb = i;
    t = 42'(p) << (23 - msb);
    return {neg, 8'(msb + h[14:10] + 102), t[22:0]};
  endfunction

  // plain formats: every element emitted, row wraps at its length
  function automatic void push_plain(input logic [31:0] v);
    elem_t e;
    e.value = v;
    e.idx = count[15:0];
    e.last_row = (32'(count) + 1 >= row_len_eff());
    e.last_item = 1'b1;
    elem_q.push_back(e);
    count = e.last_row ? 17'd0 : count + 17'd1;
  endfunction

  // block formats: elements past the row length are dropped
  function automatic bit push_block(input int q, input bit is_last);
    elem_t e;
    bit    made;
    made = 0;
    if (32'(count) < row_len_eff()) begin
      e.value = block_product(q, scale);
      e.idx = count[15:0];
      e.last_row = (32'(count) + 1 == row_len_eff());
      e.last_item = is_last;
      elem_q.push_back(e);
      made = 1;
    end
    count = count + 17'd1;
    return made;
  endfunction

  // predict the results of one accepted byte
  function automatic void predict_byte(input logic [7:0] d);
    bit lo_made;
    bit hi_made;
    logic [5:0] endp;
    case (fmt)
      bdq_pkg::FMT_F32: begin
        if (phase < 6'd3) begin
          asm_bytes = asm_bytes | (24'(d) << (8 * phase));
          phase++;
        end else begin
          phase = 6'd0;
          push_plain({d, asm_bytes});
          asm_bytes = 24'd0;
        end
      end
      bdq_pkg::FMT_F16: begin
        if (phase == 6'd0) begin
          asm_bytes = 24'(d);
          phase = 6'd1;
        end else begin
          phase = 6'd0;
          push_plain(f16_widen({d, asm_bytes[7:0]}));
          asm_bytes = 24'd0;
        end
      end
      default: begin
        endp = (fmt == bdq_pkg::FMT_Q4_0) ? bdq_pkg::Q4EndPhase : bdq_pkg::Q8EndPhase;
        if (phase == 6'd0) begin
          asm_bytes = 24'(d);
          phase = 6'd1;
        end else if (phase == 6'd1) begin
          scale = {d, asm_bytes[7:0]};
          asm_bytes = 24'd0;
          phase = 6'd2;
        end else begin
          if (fmt == bdq_pkg::FMT_Q4_0) begin
            lo_made = push_block(int'(d[3:0]) - 8, 1'b0);
            hi_made = push_block(int'(d[7:4]) - 8, 1'b1);
            // with only the low nibble emitted it is the last of the byte
            if (lo_made && !hi_made) elem_q[$].last_item = 1'b1;
          end else begin
            hi_made = push_block(int'($signed(d)), 1'b1);
          end
          if (phase >= endp) begin
            phase = 6'd0;
            if (32'(count) >= row_len_eff()) count = 17'd0;
          end else begin
            phase++;
          end
        end
      end
    endcase
  endfunction

  // sample all channels at the edge
  always @(posedge clk_i or negedge rst_ni) begin
    elem_t e;
    if (!rst_ni) begin
      fmt = bdq_pkg::FMT_F32;
      rlen = bdq_pkg::LenReset;
      phase = 6'd0;
      asm_bytes = 24'd0;
      scale = 16'd0;
      count = 17'd0;
      fail_count_o <= 0;
      checked_o <= 0;
      elem_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i &&
          (cfg_index_i == bdq_pkg::REG_FORMAT || cfg_index_i == bdq_pkg::REG_ROW_LEN)) begin
        if (cfg_index_i == bdq_pkg::REG_FORMAT) fmt = bdq_pkg::fmt_e'(cfg_data_i[1:0]);
        else rlen = cfg_data_i;
        phase = 6'd0;
        asm_bytes = 24'd0;
        scale = 16'd0;
        count = 17'd0;
      end
      if (in_valid_i && !in_stall_i) predict_byte(data_byte_i);
      if (out_valid_i && !out_stall_i) begin
        checked_o <= checked_o + 1;
        if (elem_q.size() == 0) begin
          $error("unexpected result value_bits=%h", value_bits_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = elem_q.pop_front();
          if (value_bits_i !== e.value ||
              element_index_i !== e.idx ||
              last_of_row_i !== e.last_row ||
              last_of_item_i !== e.last_item)
            fail_count_o <= fail_count_o + 1;
          if (value_bits_i !== e.value)
            $error("value_bits expected %h actual %h", e.value, value_bits_i);
          if (element_index_i !== e.idx)
            $error("element_index expected %0d actual %0d", e.idx, element_index_i);
          if (last_of_row_i !== e.last_row)
            $error("last_of_row expected %b actual %b", e.last_row, last_of_row_i);
          if (last_of_item_i !== e.last_item)
            $error("last_of_item expected %b actual %b", e.last_item, last_of_item_i);
        end
      end
    end
  end

endmodule

>>> tb/block_dequantizer_f16_q4_q8_top_tb.sv
// row dequantizer testbench top: clock, reset, config writes, byte stimulus
// and verdict; depends on bdq_pkg, the block and its checker
module block_dequantizer_f16_q4_q8_top_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] value_bits_o;
  logic [15:0] element_index_o;
  logic        last_of_row_o;
  logic        last_of_item_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = 2'd0;
  logic [16:0] cfg_data_i = 17'd0;

  int fail_count;
  int pending;
  int checked;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  int bytes_sent = 0;

  block_dequantizer_f16_q4_q8_top DUT (.*);

  block_dequantizer_f16_q4_q8_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .data_byte_i,
    .out_valid_i(out_valid_o), .out_stall_i, .value_bits_i(value_bits_o),
    .element_index_i(element_index_o), .last_of_row_i(last_of_row_o),
    .last_of_item_i(last_of_item_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending),
    .checked_o(checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver stall, with a long counted hold-off on request
  always @(posedge clk_i) begin
    int hold_left;
    if (hold_req && hold_left == 0) hold_left = 300;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

  // one byte request, with a random gap first; called at a rising edge
  task automatic send_byte(input logic [7:0] b);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      data_byte_i <= 8'($urandom);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    bytes_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // register write request, only while the block is drained
  task automatic write_reg(input bdq_pkg::reg_e idx, input logic [16:0] val);
    bit taken;
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_idling(input int mode);
    send_idle_pct = (mode == 1) ? 75 : (mode == 3) ? 22 : 0;
    recv_stall_pct = (mode == 2) ? 75 : (mode == 3) ? 22 : 0;
  endtask

  // scale with the exponent extremes weighted up
  function automatic logic [15:0] pick_scale();
    logic [15:0] s;
    s = 16'($urandom);
    case ($urandom_range(9))
      0: s[14:10] = 5'd0;
      1: s[14:10] = 5'h1F;
      default: ;
    endcase
    return s;
  endfunction

  task automatic send_block(input bdq_pkg::fmt_e f, input logic [15:0] s);
    send_byte(s[7:0]);
    send_byte(s[15:8]);
    repeat ((f == bdq_pkg::FMT_Q4_0) ? 16 : 32) send_byte(8'($urandom));
  endtask

  initial begin
    int target;
    int start;
    bdq_pkg::fmt_e f;
    logic [16:0] len;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: f32 passthrough at reset settings
    send_byte(8'h00); send_byte(8'h00); send_byte(8'h80); send_byte(8'hFF);
    // f16 specials: signed zero, smallest denormal, infinity, nan
    write_reg(bdq_pkg::REG_FORMAT, 17'(bdq_pkg::FMT_F16));
    write_reg(bdq_pkg::REG_ROW_LEN, 17'd2);
    send_byte(8'h00); send_byte(8'h80);
    send_byte(8'h01); send_byte(8'h00);
    send_byte(8'h00); send_byte(8'h7C);
    send_byte(8'h01); send_byte(8'hFE);
    // q8_0 with an infinite scale: zero gives the canonical nan
    write_reg(bdq_pkg::REG_FORMAT, 17'(bdq_pkg::FMT_Q8_0));
    send_byte(8'h00); send_byte(8'h7C);
    send_byte(8'h00); send_byte(8'h80); send_byte(8'h7F);
    // q4_0 with a denormal scale and a row length of zero
    write_reg(bdq_pkg::REG_FORMAT, 17'(bdq_pkg::FMT_Q4_0));
    write_reg(bdq_pkg::REG_ROW_LEN, 17'd0);
    send_byte(8'h01); send_byte(8'h80);
    send_byte(8'h08); send_byte(8'hF0);
    // unknown index is ignored, widest row length saturates
    write_reg(bdq_pkg::REG_NONE2, 17'h1FFFF);
    write_reg(bdq_pkg::REG_NONE3, 17'd5);
    write_reg(bdq_pkg::REG_ROW_LEN, 17'h1FFFF);
    send_block(bdq_pkg::FMT_Q4_0, 16'h3C00);

    // random phases across formats, lengths and idling
    for (int ph = 0; ph < 16; ph++) begin
      f = bdq_pkg::fmt_e'(ph % 4);
      case ($urandom_range(7))
        0: len = 17'd1;
        1: len = 17'(bdq_pkg::MaxRowElems);
        2: len = 17'($urandom_range(17'h1FFFF, bdq_pkg::MaxRowElems + 1));
        default: len = 17'($urandom_range(80, 2));
      endcase
      write_reg(bdq_pkg::REG_FORMAT, 17'(f));
      write_reg(bdq_pkg::REG_ROW_LEN, len);
      set_idling(ph % 4);
      if (ph == 5) hold_req = 1;
      target = 115;
      start = bytes_sent;
      while (bytes_sent - start < target) begin
        if (f == bdq_pkg::FMT_F32 || f == bdq_pkg::FMT_F16 || $urandom_range(9) == 0)
          send_byte(8'($urandom));
        else
          send_block(f, pick_scale());
        hold_req = 0;
      end
    end
    set_idling(0);

    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("covered %0d bytes and %0d results over all four formats,", bytes_sent, checked);
    $display("row lengths from zero to saturation, scale extremes and output hold-off");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
